// ----- hdl/dzc_pkg.sv -----
// Shared types and constants for the delta zigzag codec.
`timescale 1ns / 1ps

package dzc_pkg;

    localparam int SAMPLE_W       = 9;
    localparam int RESULT_W       = 9;
    localparam int SCORE_BITS_DEF = 8;

    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } t_dir;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                restart;
    } t_dzc_in;

    typedef struct packed {
        logic [RESULT_W-1:0] result;
        logic                range_error;
    } t_dzc_out;

endpackage

// ----- hdl/delta_zigzag_codec.sv -----
// Top level of the delta zigzag codec: input register, datapath, result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries a sample and a
//   restart flag. Output channel (o_out_valid / i_out_ready / o_out_item)
//   carries one result and a range error flag per input transaction.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) sets the
//   direction: 0 encodes scores into codes, 1 decodes codes into scores.
//   Write it only while no transaction is in flight; it is always ready.
//   Each input transaction passes through the input register and then the
//   result register before it is offered on the output channel.
//   Throughput: one transaction per cycle unless the receiver stalls, set
//   by the last-score register update between the input and result registers.
//   Reset clears both pipeline stages, the last score and the direction
//   (encode). When the receiver stalls, the result register holds and the
//   input register fills; the input channel stalls only once both are full.
`timescale 1ns / 1ps

module delta_zigzag_codec #(
    parameter int SCORE_BITS = dzc_pkg::SCORE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dzc_pkg::t_dzc_in  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dzc_pkg::t_dzc_out o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data
);

    logic                    r_in_vld;
    dzc_pkg::t_dzc_in        r_in_item;
    logic                    r_out_vld;
    dzc_pkg::t_dzc_out       r_out_item;
    logic [SCORE_BITS-1:0]   r_last_score;
    dzc_pkg::t_dir           r_direction;

    logic                    move;
    dzc_pkg::t_dzc_out       n_out_item;
    logic                    upd;
    logic [SCORE_BITS-1:0]   n_last_score;

    assign move        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || move;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    dzc_core #(
        .SCORE_BITS (SCORE_BITS)
    ) u_core (
        .i_item       (r_in_item),
        .i_dir        (r_direction),
        .i_last_score (r_last_score),
        .o_item       (n_out_item),
        .o_upd        (upd),
        .o_score      (n_last_score)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_last_score <= '0;
            r_direction  <= dzc_pkg::DIR_ENCODE;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (move && upd) begin
                r_last_score <= n_last_score;
            end
            if (i_cfg_valid) begin
                r_direction <= dzc_pkg::t_dir'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
        if (move) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

// ----- hdl/dzc_core.sv -----
// Combinational encode and decode datapath of the delta zigzag codec.
`timescale 1ns / 1ps

module dzc_core #(
    parameter int SCORE_BITS = dzc_pkg::SCORE_BITS_DEF
) (
    input  dzc_pkg::t_dzc_in        i_item,
    input  dzc_pkg::t_dir           i_dir,
    input  logic [SCORE_BITS-1:0]   i_last_score,
    output dzc_pkg::t_dzc_out       o_item,
    output logic                    o_upd,
    output logic [SCORE_BITS-1:0]   o_score
);

    localparam int CW = ((SCORE_BITS > dzc_pkg::SAMPLE_W) ? SCORE_BITS : dzc_pkg::SAMPLE_W) + 2;
    localparam logic [CW-1:0] SMAX = CW'((64'd1 << SCORE_BITS) - 64'd1);

    logic [CW-1:0] s;
    logic [CW-1:0] l;
    logic [CW-1:0] v;
    logic [CW-1:0] up;
    logic [CW-1:0] down;
    logic [CW-1:0] val;
    logic          err;

    assign s    = CW'(i_item.sample);
    assign l    = CW'(i_last_score);
    assign v    = s - CW'(1);
    assign up   = (v + CW'(1)) >> 1;
    assign down = v >> 1;

    always_comb begin
        err = 1'b0;
        val = '0;
        unique case (i_dir)
            dzc_pkg::DIR_ENCODE: begin
                priority if (s > SMAX) begin
                    err = 1'b1;
                end else if (i_item.restart) begin
                    val = s + CW'(1);
                end else if (s > l) begin
                    val = (s - l) << 1;
                end else begin
                    val = ((l - s) << 1) + CW'(1);
                end
            end
            dzc_pkg::DIR_DECODE: begin
                priority if (s == '0) begin
                    err = 1'b1;
                end else if (i_item.restart) begin
                    err = (v > SMAX);
                    val = v;
                end else if (v[0]) begin
                    err = (up > (SMAX - l));
                    val = l + up;
                end else begin
                    err = (down > l);
                    val = l - down;
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase
    end

    assign o_upd   = !err;
    assign o_score = (i_dir == dzc_pkg::DIR_ENCODE) ? s[SCORE_BITS-1:0] : val[SCORE_BITS-1:0];

    assign o_item.result      = err ? '0 : val[dzc_pkg::RESULT_W-1:0];
    assign o_item.range_error = err;

endmodule

// ----- hdl/dzc_chk.sv -----
// Port-level assertions for the delta zigzag codec, bound to the top level.
`timescale 1ns / 1ps

module dzc_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input dzc_pkg::t_dzc_in  i_in_item,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input dzc_pkg::t_dzc_out o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result transaction changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.range_error) |-> (o_out_item.result == '0))
        else $error("range error with non-zero result");

    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without matching input transaction");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

endmodule

bind delta_zigzag_codec dzc_chk u_dzc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
